// ===== design/active_expired_priority_scheduler_core_defines.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef ACTIVE_EXPIRED_PRIORITY_SCHEDULER_CORE_DEFINES_SVH
`define ACTIVE_EXPIRED_PRIORITY_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define AEPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is high.
`define AEPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

// ===== design/aeps_pkg.sv =====
// Package with the scheduler's sizes, codes, types and helper functions.
`timescale 1ns / 1ps
package aeps_pkg;

   localparam int LEVELS     = 4;
   localparam int FIFO_DEPTH = 16;
   localparam int NQ         = 2 * LEVELS;
   localparam int LVL_W      = $clog2(LEVELS);
   localparam int Q_W        = $clog2(NQ);
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int ADDR_W     = $clog2(NQ * FIFO_DEPTH);
   localparam int ID_W       = 8;

   typedef enum logic [1:0] {
      MODE_READY   = 2'd0,
      MODE_PREEMPT = 2'd1,
      MODE_DEQUEUE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STAT_ENQ_ACTIVE  = 2'd0,
      STAT_ENQ_EXPIRED = 2'd1,
      STAT_DEQUEUED    = 2'd2,
      STAT_NONE        = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DELIVER
   } state_type;

   // Command to the queue table: at most one of push and pop is set.
   typedef struct packed {
      logic           push;
      logic           pop;
      logic [Q_W-1:0] q;
   } qt_cmd_type;

   // Queue table status: pointer of the selected queue and occupancy flags.
   typedef struct packed {
      logic [PTR_W-1:0] ptr;
      logic             full;
      logic [NQ-1:0]    nonempty;
   } qt_stat_type;

   function automatic logic [LVL_W-1:0] clamp_level(input logic [3:0] v);
      logic [LVL_W-1:0] r;
      if (v > 4'(LEVELS - 1)) r = LVL_W'(LEVELS - 1);
      else                    r = v[LVL_W-1:0];
      return r;
   endfunction

   function automatic logic [Q_W-1:0] qsel(input logic bank, input logic [LVL_W-1:0] lev);
      logic [Q_W-1:0] r;
      r = (bank ? Q_W'(LEVELS) : Q_W'(0)) + Q_W'(lev);
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] mem_addr(input logic [Q_W-1:0] q,
                                                  input logic [PTR_W-1:0] ptr);
      logic [ADDR_W-1:0] r;
      r = ADDR_W'(q) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(ptr);
      return r;
   endfunction

endpackage

// ===== design/aeps_if.sv =====
// Request and response channel interfaces of the scheduler.
`timescale 1ns / 1ps
interface aeps_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] task_id;
   logic [1:0] dyn_level;
   logic [2:0] base_level;

   modport source (output valid, mode, task_id, dyn_level, base_level, input ready);
   modport sink   (input valid, mode, task_id, dyn_level, base_level, output ready);
endinterface

interface aeps_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] out_id;
   logic [1:0] out_level;
   logic       overflow;

   modport source (output valid, status, out_id, out_level, overflow, input ready);
   modport sink   (input valid, status, out_id, out_level, overflow, output ready);
endinterface

// ===== design/aeps_store.sv =====
// Task id memory holding every FIFO of both banks, with a registered read.
`timescale 1ns / 1ps
module aeps_store
   import aeps_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [ID_W-1:0]   wdata,
   output logic [ID_W-1:0]   rdata
);

   logic [ID_W-1:0] store_ff [NQ * FIFO_DEPTH];
   logic [ID_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= store_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/aeps_qtable.sv =====
// Head, tail and fill count of every FIFO, updated through one shared unit.
`timescale 1ns / 1ps
module aeps_qtable
   import aeps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  qt_cmd_type  cmd,
   output qt_stat_type stat
);

   logic [PTR_W-1:0] head_ff  [NQ];
   logic [PTR_W-1:0] tail_ff  [NQ];
   logic [CNT_W-1:0] count_ff [NQ];

   logic [PTR_W-1:0] upd_ptr;
   logic [PTR_W-1:0] ptr_in;
   logic [CNT_W-1:0] count_in;

   // One incrementer serves the head on a pop and the tail on a push.
   always_comb begin
      upd_ptr = cmd.pop ? head_ff[cmd.q] : tail_ff[cmd.q];
      if (upd_ptr == PTR_W'(FIFO_DEPTH - 1)) ptr_in = '0;
      else                                   ptr_in = upd_ptr + PTR_W'(1);
      count_in = cmd.pop ? count_ff[cmd.q] - CNT_W'(1) : count_ff[cmd.q] + CNT_W'(1);
   end

   always_comb begin
      stat.ptr  = upd_ptr;
      stat.full = (count_ff[cmd.q] == CNT_W'(FIFO_DEPTH));
      for (int i = 0; i < NQ; i++) begin
         stat.nonempty[i] = (count_ff[i] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NQ; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else if (cmd.push) begin
         tail_ff[cmd.q]  <= ptr_in;
         count_ff[cmd.q] <= count_in;
      end else if (cmd.pop) begin
         head_ff[cmd.q]  <= ptr_in;
         count_ff[cmd.q] <= count_in;
      end
   end

endmodule

// ===== design/active_expired_priority_scheduler_core.sv =====
// Top level of the two-bank multilevel priority scheduler.
//
// The request channel carries one operation per transaction: a ready
// enqueue, a preempted enqueue or a dequeue. The response channel returns
// exactly one transaction per request, in request order, with the status,
// the dequeued id, the level used and an overflow flag for a dropped push.
// A request is accepted in the idle state; the next cycle decodes it,
// updates the queue table and reads or writes the id memory; the delivery
// state that follows loads the response register once it is free. A new
// request is taken in that same loading cycle, so the block cannot take a
// new request before the last one has reached its response load, which
// waits for the registered read of the id memory.
// When the receiver stalls, the finished response waits in its register;
// one further request is then worked up to the loading step and held there.
// A synchronous reset empties every FIFO, makes bank one active and drops
// any response in flight. The id memory is not cleared; only written
// entries are ever read.
`timescale 1ns / 1ps
`include "active_expired_priority_scheduler_core_defines.svh"
module active_expired_priority_scheduler_core
   import aeps_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   aeps_req_if.sink   req_chan,
   aeps_rsp_if.source rsp_chan
);

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] task_id;
      logic [1:0] dyn_level;
      logic [2:0] base_level;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [1:0] level;
      logic       ovf;
      logic       is_pop;
   } res_type;

   state_type state_ff, state_in;
   req_type   req_ff;
   res_type   res_ff, res_in;
   logic      bank_ff, bank_in;

   logic       rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   logic [7:0] rsp_id_ff;
   logic [1:0] rsp_level_ff;
   logic       rsp_ovf_ff;

   logic req_ready;
   logic req_accept;
   logic out_free;
   logic load_out;
   logic do_exec;

   qt_cmd_type  qt_cmd;
   qt_stat_type qt_stat;
   logic [ID_W-1:0] mem_rdata;

   // Decode signals of the request in execution.
   logic [LVL_W-1:0] dyn;
   logic [LVL_W-1:0] push_lev;
   logic             push_bank;
   logic [1:0]       ok_code;
   logic             want_push;
   logic             want_pop;
   logic             any_active;
   logic             eff_bank;
   logic             found;
   logic [LVL_W-1:0] pop_lev;

   // The output register can take a new response when it is empty or its
   // current transaction completes in this cycle.
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept = req_chan.valid && req_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_accept) state_in = ST_EXEC;
         ST_EXEC:    state_in = ST_DELIVER;
         ST_DELIVER: begin
            if (out_free) state_in = req_accept ? ST_EXEC : ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready = 1'b0;
      load_out  = 1'b0;
      do_exec   = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_ready = 1'b1;
         ST_EXEC:    do_exec   = 1'b1;
         ST_DELIVER: begin
            req_ready = out_free;
            load_out  = out_free;
         end
         default:    req_ready = 1'b0;
      endcase
   end

   // Decode the operation and work out the target queue of an enqueue from the request fields.
   always_comb begin
      dyn       = clamp_level({2'b00, req_ff.dyn_level});
      push_lev  = dyn;
      push_bank = bank_ff;
      ok_code   = STAT_ENQ_ACTIVE;
      want_push = 1'b0;
      want_pop  = 1'b0;
      unique case (req_ff.mode)
         MODE_READY:   want_push = 1'b1;
         MODE_PREEMPT: begin
            want_push = 1'b1;
            if (dyn != '0) begin
               push_lev = dyn - LVL_W'(1);
            end else begin
               // A task whose slice ran out at level zero moves to the expired bank at
               // its static level minus one, clamped to the top; static level zero stays zero.
               if (req_ff.base_level == 3'd0) push_lev = '0;
               else push_lev = clamp_level({1'b0, req_ff.base_level} - 4'd1);
               push_bank = !bank_ff;
               ok_code   = STAT_ENQ_EXPIRED;
            end
         end
         MODE_DEQUEUE: want_pop = 1'b1;
         default:      want_pop = 1'b0;
      endcase
   end

   // Dequeue search: swap to the other bank when the active one is empty,
   // then take the highest non-empty level of the bank in use.
   always_comb begin
      any_active = 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
         any_active = any_active | qt_stat.nonempty[qsel(bank_ff, LVL_W'(i))];
      end
      eff_bank = any_active ? bank_ff : !bank_ff;
      found    = 1'b0;
      pop_lev  = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (qt_stat.nonempty[qsel(eff_bank, LVL_W'(i))]) begin
            found   = 1'b1;
            pop_lev = LVL_W'(i);
         end
      end
   end

   // Commands to the shared pointer unit and the id memory.
   always_comb begin
      qt_cmd.q    = want_pop ? qsel(eff_bank, pop_lev) : qsel(push_bank, push_lev);
      qt_cmd.push = do_exec && want_push && !qt_stat.full;
      qt_cmd.pop  = do_exec && want_pop && found;
      bank_in     = (do_exec && want_pop && !any_active) ? !bank_ff : bank_ff;
   end

   // Result fields of the request in execution; the id follows from memory.
   always_comb begin
      res_in.status = STAT_NONE;
      res_in.level  = '0;
      res_in.ovf    = 1'b0;
      res_in.is_pop = 1'b0;
      if (want_push) begin
         res_in.level  = 2'(push_lev);
         res_in.ovf    = qt_stat.full;
         res_in.status = qt_stat.full ? STAT_NONE : ok_code;
      end else if (want_pop && found) begin
         res_in.level  = 2'(pop_lev);
         res_in.status = STAT_DEQUEUED;
         res_in.is_pop = 1'b1;
      end
   end

   aeps_qtable u_qtable (
      .clock (clock),
      .reset (reset),
      .cmd   (qt_cmd),
      .stat  (qt_stat)
   );

   aeps_store u_store (
      .clock (clock),
      .wr_en (qt_cmd.push),
      .rd_en (qt_cmd.pop),
      .addr  (mem_addr(qt_cmd.q, qt_stat.ptr)),
      .wdata (req_ff.task_id),
      .rdata (mem_rdata)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bank_ff  <= bank_in;
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff.mode       <= req_chan.mode;
         req_ff.task_id    <= req_chan.task_id;
         req_ff.dyn_level  <= req_chan.dyn_level;
         req_ff.base_level <= req_chan.base_level;
      end
      if (do_exec) begin
         res_ff <= res_in;
      end
      if (load_out) begin
         rsp_status_ff <= res_ff.status;
         rsp_id_ff     <= res_ff.is_pop ? mem_rdata : '0;
         rsp_level_ff  <= res_ff.level;
         rsp_ovf_ff    <= res_ff.ovf;
      end
   end

   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.out_id    = rsp_id_ff;
   assign rsp_chan.out_level = rsp_level_ff;
   assign rsp_chan.overflow  = rsp_ovf_ff;

   `AEPS_ASSERT_NEXT(a_accept_runs, clock, reset, req_accept, state_ff == ST_EXEC)
   `AEPS_ASSERT_NEXT(a_load_valid, clock, reset, load_out, rsp_valid_ff)
   `AEPS_ASSERT_NOW(a_no_push_pop, clock, reset, qt_cmd.push, !qt_cmd.pop && do_exec)
   `AEPS_ASSERT_NOW(a_ovf_status, clock, reset, rsp_valid_ff && rsp_ovf_ff,
                    rsp_status_ff == STAT_NONE && rsp_id_ff == '0)

endmodule

// ===== tb/sv/aeps_dispatch_checker.sv =====
// Checker that predicts every scheduler response and compares it with the response channel.
`timescale 1ns / 1ps
module aeps_dispatch_checker
   import aeps_pkg::*;
(
   input  logic clock,
   input  logic reset,
   aeps_req_if  req_mon,
   aeps_rsp_if  rsp_mon,
   output int   mismatches,
   output int   awaiting
);

   typedef struct packed {
      status_type       status;
      logic [ID_W-1:0]  id;
      logic [LVL_W-1:0] level;
      logic             overflow;
   } dispatch_type;

   // Shadow copy of both banks: one circular buffer of ids per level.
   logic [ID_W-1:0] id_ring [0:1][0:LEVELS-1][0:FIFO_DEPTH-1];
   int              rd_ptr  [0:1][0:LEVELS-1];
   int              wr_ptr  [0:1][0:LEVELS-1];
   int              fill    [0:1][0:LEVELS-1];
   logic            live_bank;

   dispatch_type    pending_dispatch[$];
   int              err_total;

   function automatic int clamp_to_levels(input int v);
      int r;
      r = (v > LEVELS - 1) ? LEVELS - 1 : v;
      return r;
   endfunction

   // Applies one request to the shadow banks and returns the response it must produce.
   function automatic dispatch_type predict_dispatch(input logic [1:0] op,
                                                     input logic [ID_W-1:0] id,
                                                     input logic [1:0] dyn,
                                                     input logic [2:0] base);
      dispatch_type r;
      int           lev;
      int           l;
      logic         bank;
      logic         any_waiting;
      logic         found;
      r = '{status: STAT_NONE, id: '0, level: '0, overflow: 1'b0};
      lev = clamp_to_levels(int'(dyn));
      unique case (op)
         MODE_READY, MODE_PREEMPT: begin
            bank     = live_bank;
            r.status = STAT_ENQ_ACTIVE;
            if (op == MODE_PREEMPT) begin
               if (lev > 0) begin
                  lev = lev - 1;
               end else begin
                  // Time slice used up at the bottom: static level less one, clamped, next round.
                  lev      = (base == 3'd0) ? 0 : clamp_to_levels(int'(base) - 1);
                  bank     = ~live_bank;
                  r.status = STAT_ENQ_EXPIRED;
               end
            end
            r.level = LVL_W'(lev);
            if (fill[bank][lev] >= FIFO_DEPTH) begin
               r.status   = STAT_NONE;
               r.overflow = 1'b1;
            end else begin
               id_ring[bank][lev][wr_ptr[bank][lev]] = id;
               wr_ptr[bank][lev] = (wr_ptr[bank][lev] + 1) % FIFO_DEPTH;
               fill[bank][lev]++;
            end
         end
         MODE_DEQUEUE: begin
            any_waiting = 1'b0;
            for (l = 0; l < LEVELS; l++)
               if (fill[live_bank][l] != 0) any_waiting = 1'b1;
            if (!any_waiting) live_bank = ~live_bank;
            found = 1'b0;
            for (l = LEVELS - 1; l >= 0; l--) begin
               if (!found && fill[live_bank][l] != 0) begin
                  r.id     = id_ring[live_bank][l][rd_ptr[live_bank][l]];
                  r.level  = LVL_W'(l);
                  r.status = STAT_DEQUEUED;
                  rd_ptr[live_bank][l] = (rd_ptr[live_bank][l] + 1) % FIFO_DEPTH;
                  fill[live_bank][l]--;
                  found = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input dispatch_type want);
      $display({"%0t ns: %s: got status=%0h id=%0h level=%0h overflow=%0h, ",
                "want status=%0d id=%0h level=%0d overflow=%0d"},
               $time, what, rsp_mon.status, rsp_mon.out_id, rsp_mon.out_level,
               rsp_mon.overflow, want.status, want.id, want.level, want.overflow);
      err_total++;
   endtask

   always @(posedge clock) begin
      dispatch_type want;
      int           b;
      int           l;
      if (reset) begin
         for (b = 0; b < 2; b++) begin
            for (l = 0; l < LEVELS; l++) begin
               rd_ptr[b][l] = 0;
               wr_ptr[b][l] = 0;
               fill[b][l]   = 0;
            end
         end
         live_bank = 1'b1;
         pending_dispatch.delete();
         err_total = 0;
      end else begin
         // The response side is checked first, so a response can never match
         // a request accepted at the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_dispatch.size() == 0) begin
               report_mismatch("response with nothing expected", '0);
            end else begin
               want = pending_dispatch.pop_front();
               if (rsp_mon.status !== want.status || rsp_mon.out_id !== want.id ||
                   rsp_mon.out_level !== want.level || rsp_mon.overflow !== want.overflow)
                  report_mismatch("response mismatch", want);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            want = predict_dispatch(req_mon.mode, req_mon.task_id,
                                    req_mon.dyn_level, req_mon.base_level);
            pending_dispatch = {pending_dispatch, want};
         end
      end
      awaiting   <= pending_dispatch.size();
      mismatches <= err_total;
   end

endmodule

// ===== tb/sv/active_expired_priority_scheduler_core_test.sv =====
// Top of the scheduler testbench: clock, reset, request and response traffic, and the verdict.
`timescale 1ns / 1ps
module active_expired_priority_scheduler_core_test;
   import aeps_pkg::*;

   // Mode code that the block has no operation for; it must answer with no effect.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Number of counted requests after which random traffic stops.
   localparam int RANDOM_ITEMS = 400;

   // Window of counted requests in which neither side inserts idle cycles.
   localparam int STEADY_FROM  = 250;
   localparam int STEADY_UNTIL = 330;

   // Point at which the receiver holds off, and for how many cycles.
   localparam int HOLD_AFTER  = 180;
   localparam int HOLD_CYCLES = 90;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aeps_req_if req_chan ();
   aeps_rsp_if rsp_chan ();

   int   mismatches;
   int   awaiting;

   // Requests accepted so far, not counting the unused mode, which only idles the block.
   int   items_sent = 0;
   logic no_idle    = 1'b0;

   always #5ns clock = ~clock;

   active_expired_priority_scheduler_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   aeps_dispatch_checker dispatch_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .mismatches (mismatches),
      .awaiting   (awaiting)
   );

   // Every input of the block gets a known value at time zero.
   initial begin
      req_chan.valid      = 1'b0;
      req_chan.mode       = MODE_READY;
      req_chan.task_id    = '0;
      req_chan.dyn_level  = '0;
      req_chan.base_level = '0;
   end

   // Offers one request, with random idle cycles ahead of it, and returns on the
   // edge at which the transaction is accepted. The valid stays high on return, so
   // a back-to-back request simply replaces the payload in the next step.
   task automatic send_op(input logic [1:0] op, input logic [ID_W-1:0] id,
                          input logic [1:0] dyn, input logic [2:0] base);
      no_idle = (items_sent >= STEADY_FROM) && (items_sent < STEADY_UNTIL);
      while (!no_idle && $urandom_range(0, 99) < 19) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= op;
      req_chan.task_id    <= id;
      req_chan.dyn_level  <= dyn;
      req_chan.base_level <= base;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (op != MODE_UNUSED) items_sent++;
   endtask

   // Stops offering and waits until the checker holds no expected response.
   // The first edge lets the count of the last accepted transaction settle.
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
   endtask

   // A request with all fields random, weighted toward the three real operations.
   task automatic send_mixed();
      int         r;
      logic [1:0] op;
      r = $urandom_range(0, 99);
      if (r < 40)      op = MODE_READY;
      else if (r < 70) op = MODE_PREEMPT;
      else if (r < 96) op = MODE_DEQUEUE;
      else             op = MODE_UNUSED;
      send_op(op, ID_W'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
              3'($urandom_range(0, 7)));
   endtask

   // Response side: random back-pressure, plus one long hold-off counted here so
   // that the block fills up and stalls the request channel behind it.
   initial begin : rsp_drain
      int   hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && !hold_done && items_sent >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (reset || hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            if (hold_left > 0) hold_left--;
         end else begin
            rsp_chan.ready <= no_idle || ($urandom_range(0, 99) >= 19);
         end
      end
   end

   // Hard stop in case the block hangs; a correct run ends far earlier.
   initial begin
      #2ms;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int         phase_no;
      int         kind;
      int         n;
      int         k;
      int         lev;
      logic [2:0] base;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A dequeue on an empty scheduler still swaps the banks,
      // so bank zero is the active one from here on.
      send_op(MODE_DEQUEUE, 8'h00, 2'd0, 3'd1);
      // The unused mode with every field at its maximum changes nothing.
      send_op(MODE_UNUSED, 8'hFF, 2'd3, 3'd7);
      // Ready enqueues at each level, with both extreme ids.
      send_op(MODE_READY, 8'h00, 2'd0, 3'd1);
      send_op(MODE_READY, 8'hFF, 2'd3, 3'd4);
      send_op(MODE_READY, 8'h5A, 2'd1, 3'd2);
      send_op(MODE_READY, 8'hA5, 2'd2, 3'd3);
      // A preempted task above the bottom level drops one level, still active.
      send_op(MODE_PREEMPT, 8'h11, 2'd3, 3'd0);
      // At the bottom level it goes to the expired bank at its static level less
      // one; a zero static level stays at zero and large ones clamp to the top.
      send_op(MODE_PREEMPT, 8'h22, 2'd0, 3'd0);
      send_op(MODE_PREEMPT, 8'h33, 2'd0, 3'd1);
      send_op(MODE_PREEMPT, 8'h44, 2'd0, 3'd4);
      send_op(MODE_PREEMPT, 8'h55, 2'd0, 3'd7);
      send_op(MODE_PREEMPT, 8'h66, 2'd0, 3'd5);
      // Drain the active bank, swap to the expired one, drain it, and then ask
      // once more with both banks empty.
      repeat (11) send_op(MODE_DEQUEUE, 8'hC3, 2'd3, 3'd6);
      wait_for_drain();

      // Random part, in phases of well-formed traffic with some noise mixed in.
      phase_no = 0;
      while (items_sent < RANDOM_ITEMS) begin
         kind = (phase_no == 0) ? 0 : $urandom_range(0, 9);
         if (kind <= 2) begin
            // Fill burst on one active level; long ones overrun the FIFO.
            lev = $urandom_range(0, LEVELS - 1);
            n   = (phase_no == 0) ? 20 : $urandom_range(12, 22);
            for (k = 0; k < n; k++) begin
               base = 3'($urandom_range(0, 7));
               if (phase_no != 0 && lev < LEVELS - 1 && $urandom_range(0, 3) == 0)
                  send_op(MODE_PREEMPT, ID_W'($urandom_range(0, 255)), 2'(lev + 1), base);
               else
                  send_op(MODE_READY, ID_W'($urandom_range(0, 255)), 2'(lev), base);
            end
         end else if (kind <= 5) begin
            // Drain burst, which also drives bank swaps once the active side empties.
            n = $urandom_range(5, 25);
            for (k = 0; k < n; k++) begin
               if ($urandom_range(0, 9) == 0)
                  send_mixed();
               else
                  send_op(MODE_DEQUEUE, ID_W'($urandom_range(0, 255)),
                          2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
            end
         end else if (kind <= 8) begin
            n = $urandom_range(10, 30);
            for (k = 0; k < n; k++) send_mixed();
         end else begin
            // Noise: any mode code, the unused one included.
            n = $urandom_range(3, 8);
            for (k = 0; k < n; k++)
               send_op(2'($urandom_range(0, 3)), ID_W'($urandom_range(0, 255)),
                       2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
         end
         // Now and then the sender pauses until every response is back.
         if (phase_no % 4 == 3) wait_for_drain();
         phase_no++;
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/aeps_pkg.sv
design/aeps_if.sv
design/aeps_store.sv
design/aeps_qtable.sv
design/active_expired_priority_scheduler_core.sv
tb/sv/aeps_dispatch_checker.sv
tb/sv/active_expired_priority_scheduler_core_test.sv
